[src/adc_smoother_to_midi_note_unit_defines.svh]
// assertion macros shared by the adc smoother to midi note unit
// no dependencies; each file that asserts includes this header
`ifndef ADC_SMOOTHER_TO_MIDI_NOTE_UNIT_DEFINES_SVH
`define ADC_SMOOTHER_TO_MIDI_NOTE_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define ADCMIDI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ADCMIDI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/adcmidi_pkg.sv]
// shared types and constants of the adc smoother to midi note unit
// no dependencies; used by adcmidi_div and the top level
package adcmidi_pkg;

    localparam int ADJ_SHIFT = 5;
    localparam int MIN_DIFF_BITS = 12;
    localparam int AVG_W = 16;
    localparam int CLAMP_W = 12;
    localparam int NOTE_W = 7;
    localparam int SCL_W = CLAMP_W + NOTE_W;

    localparam logic [CLAMP_W-1:0] CLAMP_MAX = 12'hFFF;
    localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;
    localparam logic [3:0] STATUS_OFF_HI = 4'h8;
    localparam logic [3:0] STATUS_ON_HI = 4'h9;

    localparam logic [1:0] REG_ADC_OFFSET = 2'd0;
    localparam logic [1:0] REG_MIDI_CHANNEL = 2'd1;
    localparam logic [1:0] REG_ON_VELOCITY = 2'd2;

    localparam logic [11:0] RST_ADC_OFFSET = 12'd1988;
    localparam logic [3:0] RST_MIDI_CHANNEL = 4'd0;
    localparam logic [6:0] RST_ON_VELOCITY = 7'd127;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[src/adc_smoother_to_midi_note_unit.sv]
// top level: rolling average of adc samples, block mean, note on/off beats
// depends on adcmidi_pkg, adcmidi_ram, adcmidi_div, defines header
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid / in_ready       sample
//  out      source     out_valid / out_ready     status_byte note_number velocity last_of_run
//  cfg      apb slave  psel penable pwrite pready paddr pwdata prdata
//
// each sample passes the serial divider, which gives one quotient bit a
// cycle; the last sample of a block then passes the block mean, clamp and
// scaling, and note steps before its beats are sent
// rst_n clears window sum, pointer, fill count, block state, last note; regs take reset values
// a result beat waits in the output register; a further beat stalls the
// sequencer, and in_ready is high only while the sequencer is idle
`include "adc_smoother_to_midi_note_unit_defines.svh"

module adc_smoother_to_midi_note_unit #(
    parameter int WINDOW_LEN = 128,
    parameter int BLOCK_LEN = 32,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             status_byte,
    output logic [6:0]             note_number,
    output logic [6:0]             velocity,
    output logic                   last_of_run,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int DIFF_W = ((SAMPLE_BITS > adcmidi_pkg::MIN_DIFF_BITS) ?
                             SAMPLE_BITS : adcmidi_pkg::MIN_DIFF_BITS) + 1;
    localparam int ADJ_W = DIFF_W + adcmidi_pkg::ADJ_SHIFT;
    localparam int PTR_W = $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = ADJ_W + PTR_W;
    localparam int POS_W = $clog2(BLOCK_LEN + 1);
    localparam int BSUM_W = adcmidi_pkg::AVG_W + $clog2(BLOCK_LEN + 1);
    localparam int DVD_W = SUM_W;
    localparam int DVS_W = CNT_W;
    localparam int NW = adcmidi_pkg::NOTE_W;
    // block mean by reciprocal multiplication, exact for every block sum
    localparam int RECIP_K = BSUM_W + $clog2(BLOCK_LEN);
    localparam int RM_W = BSUM_W + 1;
    localparam int PROD_W = BSUM_W + RM_W;
    localparam longint RECIP_FULL = ((longint'(1) << RECIP_K) + longint'(BLOCK_LEN) - 1) /
                                    longint'(BLOCK_LEN);
    localparam logic [RM_W-1:0] RECIP_M = RM_W'(RECIP_FULL);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUB,
        S_ADD,
        S_AVG_GO,
        S_AVG_WAIT,
        S_MEAN,
        S_SCALE,
        S_NOTE,
        S_OFF,
        S_ON
    } state_t;

    state_t state_reg, state_next;

    logic [11:0]                    adc_offset_reg, adc_offset_next;
    logic [3:0]                     channel_reg, channel_next;
    logic [6:0]                     on_vel_reg, on_vel_next;
    logic signed [ADJ_W-1:0]        adj_reg, adj_next;
    logic signed [SUM_W-1:0]        sum_reg, sum_next;
    logic [PTR_W-1:0]               ptr_reg, ptr_next;
    logic [CNT_W-1:0]               fill_reg, fill_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [BSUM_W-1:0]              bsum_reg, bsum_next;
    logic [adcmidi_pkg::AVG_W-1:0]  mean_reg, mean_next;
    logic [adcmidi_pkg::SCL_W-1:0]  scaled_reg, scaled_next;
    logic [NW-1:0]                  note_reg, note_next;
    logic [NW-1:0]                  prev_reg, prev_next;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     status_reg, status_next;
    logic [NW-1:0]                  onote_reg, onote_next;
    logic [6:0]                     vel_reg, vel_next;
    logic                           last_reg, last_next;

    logic                           in_acc;
    logic                           cfg_wr;
    logic                           full;
    logic                           slot_free;
    logic signed [DIFF_W-1:0]       diff;
    logic [SUM_W-1:0]               sum_mag;
    logic [adcmidi_pkg::AVG_W-1:0]  avg16;
    logic [PROD_W-1:0]              mean_prod;
    logic [adcmidi_pkg::CLAMP_W-1:0] clamped;
    logic [adcmidi_pkg::SCL_W-1:0]  note_acc;
    logic [NW-1:0]                  note_calc;
    logic                           ram_rd_en;
    logic                           ram_wr_en;
    logic [ADJ_W-1:0]               ram_rd_data;
    logic                           div_start;
    logic [DVD_W-1:0]               div_q;
    adcmidi_pkg::div_stat_t         div_stat;

    adcmidi_ram #(
        .WIDTH (ADJ_W),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (adj_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ptr_reg),
        .rd_data (ram_rd_data)
    );

    adcmidi_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (fill_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc = in_valid && in_ready;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign full = (fill_reg == CNT_W'(WINDOW_LEN));
    assign slot_free = !out_valid_reg || out_ready;
    assign diff = signed'(DIFF_W'(sample)) - signed'(DIFF_W'(adc_offset_reg));
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign avg16 = sum_reg[SUM_W-1] ? (~div_q[adcmidi_pkg::AVG_W-1:0] + 16'd1)
                                    : div_q[adcmidi_pkg::AVG_W-1:0];
    assign mean_prod = PROD_W'(bsum_reg) * PROD_W'(RECIP_M);
    assign clamped = (|mean_reg[adcmidi_pkg::AVG_W-1:adcmidi_pkg::CLAMP_W])
                     ? adcmidi_pkg::CLAMP_MAX : mean_reg[adcmidi_pkg::CLAMP_W-1:0];
    // divide by 4095: exact while the quotient stays below 4096
    assign note_acc = scaled_reg + adcmidi_pkg::SCL_W'(1) + (scaled_reg >> adcmidi_pkg::CLAMP_W);
    assign note_calc = note_acc[adcmidi_pkg::CLAMP_W +: NW];

    always_comb
    begin
        unique case (paddr[3:2])
            adcmidi_pkg::REG_ADC_OFFSET:   prdata = 32'(adc_offset_reg);
            adcmidi_pkg::REG_MIDI_CHANNEL: prdata = 32'(channel_reg);
            adcmidi_pkg::REG_ON_VELOCITY:  prdata = 32'(on_vel_reg);
            default:                       prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        adc_offset_next = adc_offset_reg;
        channel_next = channel_reg;
        on_vel_next = on_vel_reg;
        adj_next = adj_reg;
        sum_next = sum_reg;
        ptr_next = ptr_reg;
        fill_next = fill_reg;
        pos_next = pos_reg;
        bsum_next = bsum_reg;
        mean_next = mean_reg;
        scaled_next = scaled_reg;
        note_next = note_reg;
        prev_next = prev_reg;
        out_valid_next = out_valid_reg;
        status_next = status_reg;
        onote_next = onote_reg;
        vel_next = vel_reg;
        last_next = last_reg;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        div_start = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                adcmidi_pkg::REG_ADC_OFFSET:   adc_offset_next = pwdata[11:0];
                adcmidi_pkg::REG_MIDI_CHANNEL: channel_next = pwdata[3:0];
                adcmidi_pkg::REG_ON_VELOCITY:  on_vel_next = pwdata[6:0];
                default:                       ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    adj_next = {diff, {adcmidi_pkg::ADJ_SHIFT{1'b0}}};
                    ram_rd_en = 1'b1;
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                if (full)
                begin
                    sum_next = sum_reg - SUM_W'(signed'(ram_rd_data));
                end
                else
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                ram_wr_en = 1'b1;
                ptr_next = (ptr_reg == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_reg + PTR_W'(1);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                sum_next = sum_reg + SUM_W'(adj_reg);
                state_next = S_AVG_GO;
            end
            S_AVG_GO:
            begin
                div_start = 1'b1;
                state_next = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_stat.done)
                begin
                    bsum_next = bsum_reg + BSUM_W'(avg16);
                    if (pos_reg == POS_W'(BLOCK_LEN - 1))
                    begin
                        state_next = S_MEAN;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                        state_next = S_IDLE;
                    end
                end
            end
            S_MEAN:
            begin
                mean_next = mean_prod[RECIP_K +: adcmidi_pkg::AVG_W];
                bsum_next = '0;
                pos_next = '0;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                scaled_next = adcmidi_pkg::SCL_W'(clamped) *
                              adcmidi_pkg::SCL_W'(adcmidi_pkg::NOTE_MAX);
                state_next = S_NOTE;
            end
            S_NOTE:
            begin
                note_next = note_calc;
                if (note_calc == prev_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (prev_reg != '0)
                begin
                    state_next = S_OFF;
                end
                else
                begin
                    state_next = S_ON;
                end
            end
            S_OFF:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next = {adcmidi_pkg::STATUS_OFF_HI, channel_reg};
                    onote_next = prev_reg;
                    vel_next = '0;
                    last_next = 1'b0;
                    state_next = S_ON;
                end
            end
            S_ON:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next = {adcmidi_pkg::STATUS_ON_HI, channel_reg};
                    onote_next = note_reg;
                    vel_next = on_vel_reg;
                    last_next = 1'b1;
                    prev_next = note_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            adc_offset_reg <= adcmidi_pkg::RST_ADC_OFFSET;
            channel_reg <= adcmidi_pkg::RST_MIDI_CHANNEL;
            on_vel_reg <= adcmidi_pkg::RST_ON_VELOCITY;
            adj_reg <= '0;
            sum_reg <= '0;
            ptr_reg <= '0;
            fill_reg <= '0;
            pos_reg <= '0;
            bsum_reg <= '0;
            mean_reg <= '0;
            scaled_reg <= '0;
            note_reg <= '0;
            prev_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= '0;
            onote_reg <= '0;
            vel_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            adc_offset_reg <= adc_offset_next;
            channel_reg <= channel_next;
            on_vel_reg <= on_vel_next;
            adj_reg <= adj_next;
            sum_reg <= sum_next;
            ptr_reg <= ptr_next;
            fill_reg <= fill_next;
            pos_reg <= pos_next;
            bsum_reg <= bsum_next;
            mean_reg <= mean_next;
            scaled_reg <= scaled_next;
            note_reg <= note_next;
            prev_reg <= prev_next;
            out_valid_reg <= out_valid_next;
            status_reg <= status_next;
            onote_reg <= onote_next;
            vel_reg <= vel_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status_byte = status_reg;
    assign note_number = onote_reg;
    assign velocity = vel_reg;
    assign last_of_run = last_reg;

    `ADCMIDI_ASSERT_NEXT(a_one_item, in_acc, !in_ready, "second item taken while busy")
    `ADCMIDI_ASSERT_NEXT(a_off_then_on, out_valid && out_ready && !last_of_run,
        out_valid && last_of_run && status_byte[7:4] == adcmidi_pkg::STATUS_ON_HI,
        "note-off not followed by note-on")
    `ADCMIDI_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CNT_W'(WINDOW_LEN), "fill count overrun")
    `ADCMIDI_ASSERT_IMP(a_off_nonzero, out_valid && !last_of_run, note_number != '0,
        "note-off for note zero")

endmodule

[src/adcmidi_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module adcmidi_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/adcmidi_div.sv]
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on adcmidi_pkg and adc_smoother_to_midi_note_unit_defines.svh
`include "adc_smoother_to_midi_note_unit_defines.svh"

module adcmidi_div #(
    parameter int DVD_W = 25,
    parameter int DVS_W = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DVD_W-1:0]         dividend,
    input  logic [DVS_W-1:0]         divisor,
    output logic [DVD_W-1:0]         quotient,
    output adcmidi_pkg::div_stat_t   stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;

    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh = {rem_reg, q_reg[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        if (start)
        begin
            q_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sub[DVS_W-1:0];
                q_next = {q_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DVS_W-1:0];
                q_next = {q_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
            rem_reg <= '0;
            dvs_reg <= '0;
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            q_reg <= q_next;
            rem_reg <= rem_next;
            dvs_reg <= dvs_next;
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `ADCMIDI_ASSERT_IMP(a_div_no_restart, start, !busy_reg, "divider restarted while busy")
    `ADCMIDI_ASSERT_IMP(a_div_done_idle, done_reg, !busy_reg && cnt_reg == '0, "done while busy")
    `ADCMIDI_ASSERT_NEXT(a_div_start_busy, start, busy_reg && !done_reg, "start did not run")

endmodule
